FILE: rtl/sac_pkg.sv
// Shared types and constants for the set-associative LRU cache model.
package sac_pkg;

   // Geometry. NUM_SETS and NUM_WAYS are powers of two.
   localparam int NUM_SETS    = 16;
   localparam int NUM_WAYS    = 4;
   localparam int SET_W       = $clog2(NUM_SETS);
   localparam int WAY_W       = $clog2(NUM_WAYS);
   localparam int RANK_W      = $clog2(NUM_WAYS);
   localparam int WCNT_W      = $clog2(NUM_WAYS + 1);
   localparam int ADDR_W      = 64;
   localparam int TAG_W       = 64;
   localparam int CNT_W       = 32;

   // Request queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Configuration port.
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 6;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SET_INDEX_BITS = 2'd0,
      CSR_OFFSET_BITS    = 2'd1,
      CSR_WAYS_IN_USE    = 2'd2,
      CSR_UNUSED         = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_STORE  = 2'd1,
      OP_MODIFY = 2'd2,
      OP_IFETCH = 2'd3
   } opcode_type;

   // Classified request as it sits in the queue.
   typedef struct packed {
      logic                lookup;
      logic                modify;
      logic [SET_W-1:0]    set_idx;
      logic [TAG_W-1:0]    tag;
      logic [NUM_WAYS-1:0] way_en;
   } req_type;

   // Result as produced by the back end.
   typedef struct packed {
      logic             valid;
      logic [1:0]       hit_count;
      logic             missed;
      logic             evicted;
      logic [CNT_W-1:0] total_hits;
      logic [CNT_W-1:0] total_misses;
      logic [CNT_W-1:0] total_evictions;
   } rsp_type;

endpackage

FILE: rtl/set_assoc_lru_cache_sim.sv
// Top level of the set-associative cache model with true LRU replacement.
// A request (opcode, address) is taken at a clock edge with start high and busy low.
// The front end splits the address into tag and set with the current configuration
// and drops the request into a two-entry queue; busy is high only while that queue
// is full. The back end takes one request at a time: in its idle state it pops the
// request and reads the set's tag row from the tag memory, in its execute state it
// compares, picks the way and writes back valid bits, recency ranks and, on a fill,
// tags. That read-modify-write of the set holds the next request in the queue until
// it is done, and the result is registered onto the rsp_ ports. Each result is shown
// for exactly one cycle with rsp_valid high; the receiver cannot stall it. Instruction
// fetches still produce a result with zero flags and unchanged totals. Valid bits clear
// and recency ranks take their way numbers at reset with no sweep, so requests are taken right away.
// Configuration registers (0 set index bits, 1 offset bits, 2 ways in use) are
// written through csr_valid/csr_ready and must only change while the block is idle.
module set_assoc_lru_cache_sim (
   input  logic                           clock,
   input  logic                           reset,

   // request channel
   input  logic                           start,
   output logic                           busy,
   input  logic [1:0]                     req_opcode,
   input  logic [sac_pkg::ADDR_W-1:0]     req_address,

   // result channel
   output logic                           rsp_valid,
   output logic [1:0]                     rsp_hit_count,
   output logic                           rsp_missed,
   output logic                           rsp_evicted,
   output logic [sac_pkg::CNT_W-1:0]      rsp_total_hits,
   output logic [sac_pkg::CNT_W-1:0]      rsp_total_misses,
   output logic [sac_pkg::CNT_W-1:0]      rsp_total_evictions,

   // configuration write channel
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [sac_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sac_pkg::CSR_DATA_W-1:0] csr_data
);

   logic             q_full;
   logic             q_push;
   logic             q_pop;
   logic             q_not_empty;
   sac_pkg::req_type q_push_item;
   sac_pkg::req_type q_pop_item;
   sac_pkg::rsp_type rsp;

   // Accept, configuration and address split.
   sac_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_opcode  (req_opcode),
      .req_address (req_address),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .q_full      (q_full),
      .push        (q_push),
      .push_item   (q_push_item)
   );

   // Decouples accept from the set read-modify-write.
   sac_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (q_pop_item),
      .not_empty (q_not_empty)
   );

   // Lookup, replacement and totals.
   sac_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_item      (q_pop_item),
      .pop         (q_pop),
      .rsp         (rsp)
   );

   assign rsp_valid           = rsp.valid;
   assign rsp_hit_count       = rsp.hit_count;
   assign rsp_missed          = rsp.missed;
   assign rsp_evicted         = rsp.evicted;
   assign rsp_total_hits      = rsp.total_hits;
   assign rsp_total_misses    = rsp.total_misses;
   assign rsp_total_evictions = rsp.total_evictions;

endmodule

FILE: rtl/sac_queue.sv
// Short request queue between the front end and the back end.
module sac_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sac_pkg::req_type push_item,
   output logic             full,
   input  logic             pop,
   output sac_pkg::req_type pop_item,
   output logic             not_empty
);

   sac_pkg::req_type                   entry_ff [sac_pkg::QUEUE_DEPTH];
   logic [sac_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [sac_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [sac_pkg::QCNT_W-1:0]         count_ff, count_in;

   assign full      = (count_ff == sac_pkg::QCNT_W'(sac_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == sac_pkg::QUEUE_DEPTH - 1) ? '0
                     : wr_ptr_ff + sac_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == sac_pkg::QUEUE_DEPTH - 1) ? '0
                     : rd_ptr_ff + sac_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + sac_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - sac_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: rtl/sac_front.sv
// Front end: configuration registers, request accept and address split.
module sac_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_opcode,
   input  logic [sac_pkg::ADDR_W-1:0]       req_address,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sac_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sac_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic                             q_full,
   output logic                             push,
   output sac_pkg::req_type                 push_item
);

   logic [2:0]                  set_bits_ff;
   logic [5:0]                  offset_bits_ff;
   logic [2:0]                  ways_ff;

   logic [sac_pkg::ADDR_W-1:0]  above;
   logic [6:0]                  tag_shift;
   logic [sac_pkg::SET_W-1:0]   set_mask;
   logic [sac_pkg::WCNT_W-1:0]  eff_ways;
   logic                        is_lookup;

   assign csr_ready = 1'b1;
   assign busy      = q_full;
   assign push      = start && !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff    <= 3'd4;
         offset_bits_ff <= 6'd4;
         ways_ff        <= 3'd4;
      end else if (csr_valid && csr_ready) begin
         case (sac_pkg::csr_index_type'(csr_index))
            sac_pkg::CSR_SET_INDEX_BITS: set_bits_ff    <= csr_data[2:0];
            sac_pkg::CSR_OFFSET_BITS:    offset_bits_ff <= csr_data[5:0];
            sac_pkg::CSR_WAYS_IN_USE:    ways_ff        <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   // Offset, set and tag fields; a tag shift of 64 or more leaves no tag.
   always_comb begin
      above     = req_address >> offset_bits_ff;
      tag_shift = {1'b0, offset_bits_ff} + {4'b0, set_bits_ff};
      for (int i = 0; i < sac_pkg::SET_W; i++) begin
         set_mask[i] = (32'(set_bits_ff) > i);
      end
      if (ways_ff == 3'd0) begin
         eff_ways = sac_pkg::WCNT_W'(1);
      end else if (32'(ways_ff) > sac_pkg::NUM_WAYS) begin
         eff_ways = sac_pkg::WCNT_W'(sac_pkg::NUM_WAYS);
      end else begin
         eff_ways = sac_pkg::WCNT_W'(ways_ff);
      end
      is_lookup = (sac_pkg::opcode_type'(req_opcode) != sac_pkg::OP_IFETCH);

      push_item.lookup  = is_lookup;
      push_item.modify  = (sac_pkg::opcode_type'(req_opcode) == sac_pkg::OP_MODIFY);
      push_item.set_idx = above[sac_pkg::SET_W-1:0] & set_mask;
      push_item.tag     = tag_shift[6] ? '0 : (req_address >> tag_shift[5:0]);
      for (int w = 0; w < sac_pkg::NUM_WAYS; w++) begin
         push_item.way_en[w] = (32'(eff_ways) > w);
      end
   end

endmodule

FILE: rtl/sac_back.sv
// Back end: tag lookup, LRU update, fill/evict and running totals.
module sac_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_not_empty,
   input  sac_pkg::req_type q_item,
   output logic             pop,
   output sac_pkg::rsp_type rsp
);

   typedef enum logic {S_IDLE, S_EXEC} state_type;

   typedef logic [sac_pkg::NUM_WAYS-1:0][sac_pkg::TAG_W-1:0]  tag_row_type;
   typedef logic [sac_pkg::NUM_WAYS-1:0][sac_pkg::RANK_W-1:0] rank_row_type;

   state_type                    state_ff, state_in;
   sac_pkg::req_type             cur_ff;

   tag_row_type                  tag_mem [sac_pkg::NUM_SETS];
   tag_row_type                  tag_row_ff, tag_row_in;
   logic                         tag_we;

   logic [sac_pkg::NUM_WAYS-1:0] valid_ff [sac_pkg::NUM_SETS];
   rank_row_type                 rank_ff [sac_pkg::NUM_SETS];
   logic [sac_pkg::NUM_WAYS-1:0] valid_row_in;
   rank_row_type                 rank_row_in;

   logic [sac_pkg::CNT_W-1:0]    hit_total_ff, hit_total_in;
   logic [sac_pkg::CNT_W-1:0]    miss_total_ff, miss_total_in;
   logic [sac_pkg::CNT_W-1:0]    evict_total_ff, evict_total_in;
   logic                         rsp_valid_ff;
   logic [1:0]                   rsp_hits_ff, rsp_hits_in;
   logic                         rsp_missed_ff, rsp_missed_in;
   logic                         rsp_evicted_ff, rsp_evicted_in;

   logic [sac_pkg::NUM_WAYS-1:0] row_valid;
   rank_row_type                 row_rank;
   logic                         found, has_empty;
   logic [sac_pkg::WAY_W-1:0]    hit_way, empty_way, lru_way, pos;
   logic [sac_pkg::RANK_W-1:0]   worst, old_rank;
   logic [sac_pkg::CNT_W:0]      hit_sum;

   assign pop = (state_ff == S_IDLE) && q_not_empty;

   always_comb begin
      row_valid = valid_ff[cur_ff.set_idx];
      row_rank  = rank_ff[cur_ff.set_idx];

      // Lowest matching way wins on duplicate tags.
      found   = 1'b0;
      hit_way = '0;
      for (int w = sac_pkg::NUM_WAYS - 1; w >= 0; w--) begin
         if (cur_ff.way_en[w] && row_valid[w] && (tag_row_ff[w] == cur_ff.tag)) begin
            found   = 1'b1;
            hit_way = sac_pkg::WAY_W'(w);
         end
      end

      // Highest empty way in use.
      has_empty = 1'b0;
      empty_way = '0;
      for (int w = 0; w < sac_pkg::NUM_WAYS; w++) begin
         if (cur_ff.way_en[w] && !row_valid[w]) begin
            has_empty = 1'b1;
            empty_way = sac_pkg::WAY_W'(w);
         end
      end

      // Oldest way in use; way 0 is always in use.
      worst   = '0;
      lru_way = '0;
      for (int w = 0; w < sac_pkg::NUM_WAYS; w++) begin
         if ((w == 0) || (cur_ff.way_en[w] && (row_rank[w] > worst))) begin
            worst   = row_rank[w];
            lru_way = sac_pkg::WAY_W'(w);
         end
      end

      pos = found ? hit_way : (has_empty ? empty_way : lru_way);

      // Move pos to most recent; the ways ahead of it age by one.
      old_rank    = row_rank[pos];
      rank_row_in = row_rank;
      for (int w = 0; w < sac_pkg::NUM_WAYS; w++) begin
         if (row_rank[w] < old_rank) begin
            rank_row_in[w] = row_rank[w] + sac_pkg::RANK_W'(1);
         end
      end
      rank_row_in[pos] = '0;

      valid_row_in      = row_valid;
      valid_row_in[pos] = 1'b1;

      tag_row_in      = tag_row_ff;
      tag_row_in[pos] = cur_ff.tag;
      tag_we          = (state_ff == S_EXEC) && cur_ff.lookup && !found;

      rsp_missed_in  = cur_ff.lookup && !found;
      rsp_evicted_in = rsp_missed_in && !has_empty;
      rsp_hits_in    = {1'b0, cur_ff.lookup && found} + {1'b0, cur_ff.modify};

      hit_sum        = {1'b0, hit_total_ff} + (sac_pkg::CNT_W + 1)'(rsp_hits_in);
      hit_total_in   = hit_sum[sac_pkg::CNT_W] ? '1 : hit_sum[sac_pkg::CNT_W-1:0];
      miss_total_in  = (rsp_missed_in && (miss_total_ff != '1))
                       ? miss_total_ff + sac_pkg::CNT_W'(1) : miss_total_ff;
      evict_total_in = (rsp_evicted_in && (evict_total_ff != '1))
                       ? evict_total_ff + sac_pkg::CNT_W'(1) : evict_total_ff;

      case (state_ff)
         S_IDLE:  state_in = q_not_empty ? S_EXEC : S_IDLE;
         S_EXEC:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         hit_total_ff   <= '0;
         miss_total_ff  <= '0;
         evict_total_ff <= '0;
         for (int s = 0; s < sac_pkg::NUM_SETS; s++) begin
            valid_ff[s] <= '0;
            for (int w = 0; w < sac_pkg::NUM_WAYS; w++) begin
               rank_ff[s][w] <= sac_pkg::RANK_W'(w);
            end
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == S_EXEC);
         if (pop) begin
            cur_ff <= q_item;
         end
         if (state_ff == S_EXEC) begin
            rsp_hits_ff    <= rsp_hits_in;
            rsp_missed_ff  <= rsp_missed_in;
            rsp_evicted_ff <= rsp_evicted_in;
            hit_total_ff   <= hit_total_in;
            miss_total_ff  <= miss_total_in;
            evict_total_ff <= evict_total_in;
            if (cur_ff.lookup) begin
               valid_ff[cur_ff.set_idx] <= valid_row_in;
               rank_ff[cur_ff.set_idx]  <= rank_row_in;
            end
         end
      end
   end

   // Tag store: one row per set, read on pop, written back on a fill.
   always_ff @(posedge clock) begin
      if (pop) begin
         tag_row_ff <= tag_mem[q_item.set_idx];
      end
      if (tag_we) begin
         tag_mem[cur_ff.set_idx] <= tag_row_in;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.hit_count       = rsp_hits_ff;
   assign rsp.missed          = rsp_missed_ff;
   assign rsp.evicted         = rsp_evicted_ff;
   assign rsp.total_hits      = hit_total_ff;
   assign rsp.total_misses    = miss_total_ff;
   assign rsp.total_evictions = evict_total_ff;

   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == S_EXEC))
      else $error("result strobe without a preceding execute cycle");

   a_evict_is_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_evicted_ff) |-> rsp_missed_ff)
      else $error("eviction reported without a miss");

   a_miss_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_missed_ff) |-> (miss_total_ff != '0))
      else $error("miss reported but miss total is zero");

   a_hits_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (hit_total_ff >= $past(hit_total_ff)))
      else $error("hit total decreased");

endmodule
